@@ design/assert_macros.svh @@
// assertion macros used by the scanner's match core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, masked while reset is held
`define PKRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked in the cycle after the trigger
`define PKRS_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (prop)) else $error(msg);

`endif

@@ design/pkrs_pkg.sv @@
// shared types and constants for the partition key run-in scanner
package pkrs_pkg;

    localparam int PREFIX_MATCH_LEN = 11;
    localparam int KEY_LEN          = 16;
    localparam int POS_W            = 5;
    localparam int PREFIX_IDX_W     = $clog2(PREFIX_MATCH_LEN);
    localparam int COUNT_W          = 17;
    localparam int RUNIN_W          = 16;

    // key octet positions from the last prefix octet onward
    localparam logic [POS_W-1:0] POS_PREFIX_LAST = POS_W'(PREFIX_MATCH_LEN - 1);
    localparam logic [POS_W-1:0] POS_PREFIX_END  = POS_W'(PREFIX_MATCH_LEN);
    localparam logic [POS_W-1:0] POS_TAIL_A      = POS_W'(11);
    localparam logic [POS_W-1:0] POS_TAIL_B      = POS_W'(12);
    localparam logic [POS_W-1:0] POS_KIND        = POS_W'(13);
    localparam logic [POS_W-1:0] POS_STATUS      = POS_W'(14);
    localparam logic [POS_W-1:0] POS_KEY_LAST    = POS_W'(KEY_LEN - 1);

    localparam logic [7:0] TAIL_BYTE        = 8'h01;
    localparam logic [7:0] KIND_HEADER      = 8'h02;
    localparam logic [7:0] PS_CLOSED_INCOMP = 8'h02;
    localparam logic [7:0] PS_OPEN_COMPLETE = 8'h03;
    localparam logic [7:0] PS_CLOSED_COMP   = 8'h04;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_RUNIN      = 2'd1;
    localparam logic [1:0] ST_EOS        = 2'd2;
    localparam logic [1:0] ST_NOT_HEADER = 2'd3;

    localparam logic [RUNIN_W-1:0] MAX_RUNIN_RESET = '1;

    localparam logic [7:0] PP_PREFIX [0:PREFIX_MATCH_LEN-1] = '{
        8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h05,
        8'h01, 8'h01, 8'h0D, 8'h01, 8'h02
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [RUNIN_W-1:0] runin_length;
        logic               closed;
        logic               complete;
    } t_result;

endpackage

@@ design/pkrs_in_reg.sv @@
// input holding register with valid/stall handshake
module pkrs_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pkrs_pkg::t_in_word i_word,
    output logic              o_in_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output pkrs_pkg::t_in_word o_word
);
    import pkrs_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     accept;

    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ design/pkrs_match_core.sv @@
// key match state and per-word result logic
`include "assert_macros.svh"

module pkrs_match_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pkrs_pkg::t_in_word            i_word,
    input  logic [pkrs_pkg::RUNIN_W-1:0]  i_max_runin,
    output logic                          o_res_valid,
    output pkrs_pkg::t_result             o_res
);
    import pkrs_pkg::*;

    logic [POS_W-1:0]   r_match_pos,    n_match_pos;
    logic [COUNT_W-1:0] r_bytes_seen,   n_bytes_seen;
    logic               r_tail_ok,      n_tail_ok;
    logic [7:0]         r_kind_octet,   n_kind_octet;
    logic [7:0]         r_status_octet, n_status_octet;

    logic [COUNT_W-1:0] bytes_inc;
    logic [COUNT_W-1:0] late_limit;
    logic [COUNT_W-1:0] runin_full;
    logic               emit;

    assign bytes_inc  = r_bytes_seen + COUNT_W'(1);
    assign late_limit = {1'b0, i_max_runin} + COUNT_W'(PREFIX_MATCH_LEN);
    assign runin_full = r_bytes_seen - COUNT_W'(PREFIX_MATCH_LEN);

    always_comb begin
        n_match_pos    = r_match_pos;
        n_bytes_seen   = r_bytes_seen;
        n_tail_ok      = r_tail_ok;
        n_kind_octet   = r_kind_octet;
        n_status_octet = r_status_octet;
        emit           = 1'b0;
        o_res          = '0;

        if (i_valid) begin
            if (i_word.end_of_stream) begin
                emit         = 1'b1;
                o_res.status = ST_EOS;
            end else if (r_match_pos < POS_PREFIX_END) begin
                n_bytes_seen = bytes_inc;
                if (i_word.data_byte == PP_PREFIX[r_match_pos[PREFIX_IDX_W-1:0]]) begin
                    n_match_pos = r_match_pos + POS_W'(1);
                    // prefix completed with a run-in at or beyond the allowed maximum
                    if (r_match_pos == POS_PREFIX_LAST && bytes_inc >= late_limit) begin
                        emit         = 1'b1;
                        o_res.status = ST_RUNIN;
                    end
                end else begin
                    n_match_pos = '0;
                    if (bytes_inc >= {1'b0, i_max_runin}) begin
                        emit         = 1'b1;
                        o_res.status = ST_RUNIN;
                    end
                end
            end else begin
                n_match_pos = r_match_pos + POS_W'(1);
                case (r_match_pos)
                    POS_TAIL_A, POS_TAIL_B: begin
                        if (i_word.data_byte != TAIL_BYTE) begin
                            n_tail_ok = 1'b0;
                        end
                    end
                    POS_KIND: begin
                        n_kind_octet = i_word.data_byte;
                    end
                    POS_STATUS: begin
                        n_status_octet = i_word.data_byte;
                    end
                    POS_KEY_LAST: begin
                        emit = 1'b1;
                        if (r_tail_ok && r_kind_octet == KIND_HEADER) begin
                            o_res.status       = ST_FOUND;
                            o_res.runin_length = runin_full[RUNIN_W-1:0];
                            o_res.closed       = r_status_octet inside
                                {PS_CLOSED_INCOMP, PS_CLOSED_COMP};
                            o_res.complete     = r_status_octet inside
                                {PS_OPEN_COMPLETE, PS_CLOSED_COMP};
                        end else begin
                            o_res.status = ST_NOT_HEADER;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // every result restarts the search
            if (emit) begin
                n_match_pos    = '0;
                n_bytes_seen   = '0;
                n_tail_ok      = 1'b1;
                n_kind_octet   = '0;
                n_status_octet = '0;
            end
        end
    end

    assign o_res_valid = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_pos    <= '0;
            r_bytes_seen   <= '0;
            r_tail_ok      <= 1'b1;
            r_kind_octet   <= '0;
            r_status_octet <= '0;
        end else begin
            r_match_pos    <= n_match_pos;
            r_bytes_seen   <= n_bytes_seen;
            r_tail_ok      <= n_tail_ok;
            r_kind_octet   <= n_kind_octet;
            r_status_octet <= n_status_octet;
        end
    end

    `PKRS_ASSERT(a_pos_in_key, r_match_pos <= POS_KEY_LAST,
        "match position beyond last key octet")
    `PKRS_ASSERT(a_count_after_prefix,
        (r_match_pos < POS_PREFIX_END) || (r_bytes_seen >= COUNT_W'(PREFIX_MATCH_LEN)),
        "prefix matched with too few bytes counted")
    `PKRS_ASSERT_NEXT(a_clear_after_result, o_res_valid,
        (r_match_pos == '0) && (r_bytes_seen == '0) && r_tail_ok,
        "search state not cleared after a result")

endmodule

@@ design/partition_key_runin_scanner_unit.sv @@
// top level of the partition pack key run-in scanner
// usage:
//   input channel: i_in_valid / o_in_stall carry one word per accepted edge,
//   a file byte on i_data_byte, or i_end_of_stream high to close the stream
//   (the byte is then ignored)
//   output channel: o_out_valid / i_out_stall; at most one result word per
//   input word, giving status, run-in length and closed/complete flags
//   config: i_cfg_we writes i_cfg_wdata into max_runin (reset 65535); write
//   it only while the scanner is idle, it applies from the next byte
// timing:
//   a word is held in the input register, then matched against the search
//   state in one cycle and any result lands in the output register, so a
//   result shows on the first edge after its word is accepted
//   throughput is one word per cycle; the single-cycle state update of the
//   match logic is what sets this
// stalls: while a result waits under i_out_stall the input register can
//   still take one word if it is empty, after which o_in_stall stays high
//   until the result goes
// reset: synchronous active low; clears the search, both holding registers
//   and sets max_runin back to 65535
module partition_key_runin_scanner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input word channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    // result word channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [pkrs_pkg::RUNIN_W-1:0]  o_runin_length,
    output logic                          o_closed,
    output logic                          o_complete,
    // max_runin register
    input  logic                          i_cfg_we,
    input  logic [pkrs_pkg::RUNIN_W-1:0]  i_cfg_wdata
);
    import pkrs_pkg::*;

    logic [RUNIN_W-1:0] r_max_runin;
    logic               r_out_valid;
    t_result            r_out;

    t_in_word           in_word;
    t_in_word           held_word;
    logic               held_valid;
    logic               advance;
    logic               res_valid;
    t_result            res;

    assign in_word.data_byte     = i_data_byte;
    assign in_word.end_of_stream = i_end_of_stream;

    // held word moves on when the result slot is empty or being emptied
    assign advance = held_valid && (!r_out_valid || !i_out_stall);

    pkrs_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_word     (in_word),
        .o_in_stall (o_in_stall),
        .i_advance  (advance),
        .o_valid    (held_valid),
        .o_word     (held_word)
    );

    pkrs_match_core u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_word      (held_word),
        .i_max_runin (r_max_runin),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // run-in limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_runin <= MAX_RUNIN_RESET;
        end else if (i_cfg_we) begin
            r_max_runin <= i_cfg_wdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_runin_length = r_out.runin_length;
    assign o_closed       = r_out.closed;
    assign o_complete     = r_out.complete;

endmodule
